// ===== src/bpfrm_pkg.sv =====
// ============================================================================
// bpfrm_pkg
// shared types and constants for the buffer pool free/ready manager
// ============================================================================
package bpfrm_pkg;

    // pool size and derived widths
    localparam int NUM_BUFFERS = 8;
    localparam int IDX_W       = $clog2(NUM_BUFFERS);
    localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);
    localparam int SUM_W       = CNT_W + 1;

    // commands
    localparam logic [1:0] CMD_GET_WRITE = 2'd0;
    localparam logic [1:0] CMD_GET_READ  = 2'd1;
    localparam logic [1:0] CMD_RELEASE   = 2'd2;
    localparam logic [1:0] CMD_FORCE     = 2'd3;

    // buffer status
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_WRITE = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    // result codes
    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_EMPTY   = 2'd1;
    localparam logic [1:0] RC_STATUS  = 2'd2;
    localparam logic [1:0] RC_RELEASE = 2'd3;

    // queue control from the decoder
    typedef struct packed {
        logic             pop;
        logic             push;
        logic [IDX_W-1:0] push_data;
    } t_q_ctrl;

    // queue status to the decoder
    typedef struct packed {
        logic [IDX_W-1:0] head_data;
        logic [CNT_W-1:0] fill;
    } t_q_stat;

    // one result
    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        logic [1:0]       result_code;
        logic [1:0]       new_status;
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] ready_count;
    } t_result;

endpackage

// ===== src/buffer_pool_free_ready_manager_top.sv =====
// ============================================================================
// buffer_pool_free_ready_manager_top
// buffer pool manager with free and ready queues and per-buffer status
// ============================================================================
// usage
//   request channel: i_in_valid / o_in_stall carry i_command and
//   i_buffer_index; a request is taken on a rising edge with valid high and
//   stall low. get-for-write pops the oldest free buffer, get-for-read pops
//   the oldest ready buffer, release and force free act on i_buffer_index.
//   result channel: o_out_valid / i_out_stall carry one result per request:
//   granted index, result code, new status and both queue fill counts.
//   the result is registered into the output register, or into the skid
//   register while that one is held. throughput: one request per cycle
//   while o_in_stall is low; queue pop/push and the status table write
//   all happen at the accepting edge, so the next request sees the new pool.
//   empty queues never block: they come back as a result code.
//   reset (i_rst_n low, synchronous): free queue holds every index in order,
//   ready queue empty, all buffers free, no result pending. no clearing pass
//   is needed, the block takes requests as soon as reset is released.
//   receiver stall: the result register holds; one more result lands in a
//   skid register, and only then does o_in_stall rise.
// ============================================================================
module buffer_pool_free_ready_manager_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_command,
    input  logic [bpfrm_pkg::IDX_W-1:0]  i_buffer_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bpfrm_pkg::IDX_W-1:0]  o_granted_index,
    output logic [1:0]                   o_result_code,
    output logic [1:0]                   o_new_status,
    output logic [bpfrm_pkg::CNT_W-1:0]  o_free_count,
    output logic [bpfrm_pkg::CNT_W-1:0]  o_ready_count
);

    bpfrm_pkg::t_q_ctrl w_free_ctrl;
    bpfrm_pkg::t_q_ctrl w_ready_ctrl;
    bpfrm_pkg::t_q_stat w_free_stat;
    bpfrm_pkg::t_q_stat w_ready_stat;
    bpfrm_pkg::t_result w_result;
    bpfrm_pkg::t_result w_out;
    logic               w_full;
    logic               w_accept;

    // a request is taken whenever the skid register is free
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    // free queue starts full with all indices
    bpfrm_queue u_free_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_full (1'b1),
        .i_ctrl       (w_free_ctrl),
        .o_stat       (w_free_stat)
    );

    // ready queue starts empty
    bpfrm_queue u_ready_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_full (1'b0),
        .i_ctrl       (w_ready_ctrl),
        .o_stat       (w_ready_stat)
    );

    // decode and status table
    bpfrm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_command      (i_command),
        .i_buffer_index (i_buffer_index),
        .i_free_stat    (w_free_stat),
        .i_ready_stat   (w_ready_stat),
        .o_free_ctrl    (w_free_ctrl),
        .o_ready_ctrl   (w_ready_ctrl),
        .o_result       (w_result)
    );

    // result register and skid
    bpfrm_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_result (w_result),
        .o_full   (w_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_out)
    );

    assign o_granted_index = w_out.granted_index;
    assign o_result_code   = w_out.result_code;
    assign o_new_status    = w_out.new_status;
    assign o_free_count    = w_out.free_count;
    assign o_ready_count   = w_out.ready_count;

endmodule

// ===== src/bpfrm_queue.sv =====
// ============================================================================
// bpfrm_queue
// ring of buffer indices with head pointer and fill count
// ============================================================================
module bpfrm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start_full,
    input  bpfrm_pkg::t_q_ctrl   i_ctrl,
    output bpfrm_pkg::t_q_stat   o_stat
);

    logic [bpfrm_pkg::IDX_W-1:0] r_slot [bpfrm_pkg::NUM_BUFFERS];
    logic [bpfrm_pkg::IDX_W-1:0] r_head;
    logic [bpfrm_pkg::IDX_W-1:0] n_head;
    logic [bpfrm_pkg::CNT_W-1:0] r_fill;
    logic [bpfrm_pkg::CNT_W-1:0] n_fill;
    logic [bpfrm_pkg::SUM_W-1:0] w_head_inc;
    logic [bpfrm_pkg::SUM_W-1:0] w_pos_sum;
    logic [bpfrm_pkg::SUM_W-1:0] w_pos;
    logic                        w_push_ok;

    // tail position, wrapped once
    assign w_pos_sum = bpfrm_pkg::SUM_W'(r_head) + bpfrm_pkg::SUM_W'(r_fill);
    assign w_pos     = (w_pos_sum >= bpfrm_pkg::SUM_W'(bpfrm_pkg::NUM_BUFFERS)) ?
                       w_pos_sum - bpfrm_pkg::SUM_W'(bpfrm_pkg::NUM_BUFFERS) : w_pos_sum;
    assign w_head_inc = bpfrm_pkg::SUM_W'(r_head) + bpfrm_pkg::SUM_W'(1);
    assign w_push_ok  = i_ctrl.push &&
                        (r_fill < bpfrm_pkg::CNT_W'(bpfrm_pkg::NUM_BUFFERS));

    always_comb begin
        n_head = r_head;
        if (i_ctrl.pop) begin
            if (w_head_inc >= bpfrm_pkg::SUM_W'(bpfrm_pkg::NUM_BUFFERS)) begin
                n_head = '0;
            end else begin
                n_head = w_head_inc[bpfrm_pkg::IDX_W-1:0];
            end
        end
        n_fill = r_fill + bpfrm_pkg::CNT_W'(w_push_ok) - bpfrm_pkg::CNT_W'(i_ctrl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= i_start_full ? bpfrm_pkg::CNT_W'(bpfrm_pkg::NUM_BUFFERS) : '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // contents: indices in order at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bpfrm_pkg::NUM_BUFFERS; i++) begin
                r_slot[i] <= bpfrm_pkg::IDX_W'(i);
            end
        end else if (w_push_ok) begin
            r_slot[w_pos[bpfrm_pkg::IDX_W-1:0]] <= i_ctrl.push_data;
        end
    end

    assign o_stat.head_data = r_slot[r_head];
    assign o_stat.fill      = r_fill;

endmodule

// ===== src/bpfrm_ctrl.sv =====
// ============================================================================
// bpfrm_ctrl
// command decode, status table and result forming
// ============================================================================
module bpfrm_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [1:0]                   i_command,
    input  logic [bpfrm_pkg::IDX_W-1:0]  i_buffer_index,
    input  bpfrm_pkg::t_q_stat           i_free_stat,
    input  bpfrm_pkg::t_q_stat           i_ready_stat,
    output bpfrm_pkg::t_q_ctrl           o_free_ctrl,
    output bpfrm_pkg::t_q_ctrl           o_ready_ctrl,
    output bpfrm_pkg::t_result           o_result
);

    logic [1:0]                  r_status [bpfrm_pkg::NUM_BUFFERS];
    logic [1:0]                  w_cur;
    logic [bpfrm_pkg::IDX_W-1:0] w_granted;
    logic [1:0]                  w_code;
    logic [1:0]                  w_nst;
    logic                        w_pop_f;
    logic                        w_pop_r;
    logic                        w_push_f;
    logic                        w_push_r;
    logic                        w_st_we;

    assign w_cur = r_status[i_buffer_index];

    always_comb begin
        w_granted = '0;
        w_code    = bpfrm_pkg::RC_OK;
        w_nst     = bpfrm_pkg::ST_FREE;
        w_pop_f   = 1'b0;
        w_pop_r   = 1'b0;
        w_push_f  = 1'b0;
        w_push_r  = 1'b0;
        w_st_we   = 1'b0;
        case (i_command)
            bpfrm_pkg::CMD_GET_WRITE: begin
                if (i_free_stat.fill == '0) begin
                    w_code = bpfrm_pkg::RC_EMPTY;
                end else begin
                    // queue contents always match the status table
                    w_pop_f   = 1'b1;
                    w_granted = i_free_stat.head_data;
                    w_nst     = bpfrm_pkg::ST_WRITE;
                    w_st_we   = 1'b1;
                end
            end
            bpfrm_pkg::CMD_GET_READ: begin
                if (i_ready_stat.fill == '0) begin
                    w_code = bpfrm_pkg::RC_EMPTY;
                end else begin
                    w_pop_r   = 1'b1;
                    w_granted = i_ready_stat.head_data;
                    w_nst     = bpfrm_pkg::ST_READ;
                    w_st_we   = 1'b1;
                end
            end
            bpfrm_pkg::CMD_RELEASE: begin
                w_granted = i_buffer_index;
                w_nst     = w_cur;
                if (w_cur == bpfrm_pkg::ST_READ) begin
                    w_nst = (i_ready_stat.fill == '0) ? bpfrm_pkg::ST_READY :
                                                        bpfrm_pkg::ST_FREE;
                end else if (w_cur == bpfrm_pkg::ST_WRITE) begin
                    w_nst = (i_free_stat.fill == '0) ? bpfrm_pkg::ST_FREE :
                                                       bpfrm_pkg::ST_READY;
                end else begin
                    w_code = bpfrm_pkg::RC_RELEASE;
                end
                if (w_code == bpfrm_pkg::RC_OK) begin
                    w_st_we  = 1'b1;
                    w_push_f = (w_nst == bpfrm_pkg::ST_FREE);
                    w_push_r = (w_nst != bpfrm_pkg::ST_FREE);
                end
            end
            default: begin
                // force free
                w_granted = i_buffer_index;
                w_nst     = w_cur;
                if (w_cur == bpfrm_pkg::ST_FREE || w_cur == bpfrm_pkg::ST_READY) begin
                    w_code = bpfrm_pkg::RC_STATUS;
                end else begin
                    w_nst    = bpfrm_pkg::ST_FREE;
                    w_st_we  = 1'b1;
                    w_push_f = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bpfrm_pkg::NUM_BUFFERS; i++) begin
                r_status[i] <= bpfrm_pkg::ST_FREE;
            end
        end else if (i_accept && w_st_we) begin
            r_status[w_granted] <= w_nst;
        end
    end

    assign o_free_ctrl.pop        = i_accept && w_pop_f;
    assign o_free_ctrl.push       = i_accept && w_push_f;
    assign o_free_ctrl.push_data  = i_buffer_index;
    assign o_ready_ctrl.pop       = i_accept && w_pop_r;
    assign o_ready_ctrl.push      = i_accept && w_push_r;
    assign o_ready_ctrl.push_data = i_buffer_index;

    assign o_result.granted_index = w_granted;
    assign o_result.result_code   = w_code;
    assign o_result.new_status    = w_nst;
    assign o_result.free_count    = i_free_stat.fill + bpfrm_pkg::CNT_W'(w_push_f)
                                    - bpfrm_pkg::CNT_W'(w_pop_f);
    assign o_result.ready_count   = i_ready_stat.fill + bpfrm_pkg::CNT_W'(w_push_r)
                                    - bpfrm_pkg::CNT_W'(w_pop_r);

endmodule

// ===== src/bpfrm_out_buf.sv =====
// ============================================================================
// bpfrm_out_buf
// result register with a skid stage behind it
// ============================================================================
module bpfrm_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bpfrm_pkg::t_result  i_result,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output bpfrm_pkg::t_result  o_result
);

    logic               r_out_valid;
    logic               r_skid_valid;
    bpfrm_pkg::t_result r_out;
    bpfrm_pkg::t_result r_skid;
    logic               w_take;

    assign w_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_take) begin
                r_out_valid  <= r_skid_valid || i_load;
                r_skid_valid <= r_skid_valid && i_load;
            end else begin
                r_skid_valid <= r_skid_valid || i_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_load) begin
                    r_skid <= i_result;
                end
            end else if (i_load) begin
                r_out <= i_result;
            end
        end else if (i_load) begin
            r_skid <= i_result;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== src/bpfrm_checker.sv =====
// ============================================================================
// bpfrm_checker
// port-level checks for the buffer pool manager
// ============================================================================
module bpfrm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [bpfrm_pkg::IDX_W-1:0]  o_granted_index,
    input logic [1:0]                   o_result_code,
    input logic [1:0]                   o_new_status,
    input logic [bpfrm_pkg::CNT_W-1:0]  o_free_count,
    input logic [bpfrm_pkg::CNT_W-1:0]  o_ready_count
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    // the two queue counts together never exceed the pool size
    a_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (bpfrm_pkg::SUM_W'(o_free_count) + bpfrm_pkg::SUM_W'(o_ready_count)
                         <= bpfrm_pkg::SUM_W'(bpfrm_pkg::NUM_BUFFERS)))
        else $error("queue counts exceed pool");

    // empty report carries zero index and free status
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_code == bpfrm_pkg::RC_EMPTY |->
        o_granted_index == '0 && o_new_status == bpfrm_pkg::ST_FREE)
        else $error("empty result with payload");

    // rejected release only on a free or ready buffer
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_code == bpfrm_pkg::RC_RELEASE |->
        o_new_status == bpfrm_pkg::ST_FREE || o_new_status == bpfrm_pkg::ST_READY)
        else $error("release rejected on busy buffer");

endmodule

bind buffer_pool_free_ready_manager_top bpfrm_checker u_bpfrm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_granted_index (o_granted_index),
    .o_result_code   (o_result_code),
    .o_new_status    (o_new_status),
    .o_free_count    (o_free_count),
    .o_ready_count   (o_ready_count)
);

// ===== tb/pool_result_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// pool_result_checker
// watches the request and result channels of the buffer pool manager, keeps
// its own copy of the pool and compares every result with its prediction
// ============================================================================
module pool_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [1:0]                      i_command,
    input  logic [bpfrm_pkg::IDX_W-1:0]     i_buffer_index,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [bpfrm_pkg::IDX_W-1:0]     i_granted_index,
    input  logic [1:0]                      i_result_code,
    input  logic [1:0]                      i_new_status,
    input  logic [bpfrm_pkg::CNT_W-1:0]     i_free_count,
    input  logic [bpfrm_pkg::CNT_W-1:0]     i_ready_count,
    output int                              o_fail_count,
    output int                              o_pending_count
);

    // shadow pool
    logic [bpfrm_pkg::IDX_W-1:0] free_q[$];
    logic [bpfrm_pkg::IDX_W-1:0] ready_q[$];
    logic [1:0]                  buf_status [bpfrm_pkg::NUM_BUFFERS];

    bpfrm_pkg::t_result pending_results[$];
    int                 mismatches = 0;

    assign o_fail_count = mismatches;

    // print one result with a leading tag
    task automatic show_result(input string tag, input bpfrm_pkg::t_result r);
        $display("%s idx %0d code %0d status %0d free %0d ready %0d",
                 tag, r.granted_index, r.result_code, r.new_status,
                 r.free_count, r.ready_count);
    endtask

    // one command against the shadow pool, returns the result it must give
    function automatic bpfrm_pkg::t_result apply_pool_command(
        logic [1:0] cmd, logic [bpfrm_pkg::IDX_W-1:0] idx);
        bpfrm_pkg::t_result          r;
        logic [bpfrm_pkg::IDX_W-1:0] b;
        logic [1:0]                  cur;
        logic [1:0]                  want_st;
        logic [1:0]                  next_st;
        r = '0;
        r.result_code = bpfrm_pkg::RC_OK;
        r.new_status  = bpfrm_pkg::ST_FREE;
        if (cmd == bpfrm_pkg::CMD_GET_WRITE || cmd == bpfrm_pkg::CMD_GET_READ) begin
            want_st = (cmd == bpfrm_pkg::CMD_GET_WRITE) ? bpfrm_pkg::ST_FREE :
                                                          bpfrm_pkg::ST_READY;
            next_st = (cmd == bpfrm_pkg::CMD_GET_WRITE) ? bpfrm_pkg::ST_WRITE :
                                                          bpfrm_pkg::ST_READ;
            if ((cmd == bpfrm_pkg::CMD_GET_WRITE && free_q.size() == 0) ||
                (cmd == bpfrm_pkg::CMD_GET_READ && ready_q.size() == 0)) begin
                r.result_code = bpfrm_pkg::RC_EMPTY;
            end else begin
                if (cmd == bpfrm_pkg::CMD_GET_WRITE)
                    b = free_q.pop_front();
                else
                    b = ready_q.pop_front();
                r.granted_index = b;
                if (buf_status[b] != want_st) begin
                    r.result_code = bpfrm_pkg::RC_STATUS;
                    r.new_status  = buf_status[b];
                end else begin
                    buf_status[b] = next_st;
                    r.new_status  = next_st;
                end
            end
        end else begin
            // every 3-bit index lies inside an 8-entry pool
            r.granted_index = idx;
            cur = buf_status[idx];
            r.new_status = cur;
            if (cmd == bpfrm_pkg::CMD_RELEASE) begin
                if (cur == bpfrm_pkg::ST_READ)
                    r.new_status = (ready_q.size() == 0) ? bpfrm_pkg::ST_READY :
                                                           bpfrm_pkg::ST_FREE;
                else if (cur == bpfrm_pkg::ST_WRITE)
                    r.new_status = (free_q.size() == 0) ? bpfrm_pkg::ST_FREE :
                                                          bpfrm_pkg::ST_READY;
                else
                    r.result_code = bpfrm_pkg::RC_RELEASE;
            end else begin
                if (cur == bpfrm_pkg::ST_FREE || cur == bpfrm_pkg::ST_READY)
                    r.result_code = bpfrm_pkg::RC_STATUS;
                else
                    r.new_status = bpfrm_pkg::ST_FREE;
            end
            if (r.result_code == bpfrm_pkg::RC_OK) begin
                buf_status[idx] = r.new_status;
                if (r.new_status == bpfrm_pkg::ST_FREE)
                    free_q.push_back(idx);
                else
                    ready_q.push_back(idx);
            end
        end
        r.free_count  = bpfrm_pkg::CNT_W'(free_q.size());
        r.ready_count = bpfrm_pkg::CNT_W'(ready_q.size());
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        bpfrm_pkg::t_result seen;
        bpfrm_pkg::t_result want;
        int                 i;
        if (!i_rst_n) begin
            free_q.delete();
            ready_q.delete();
            for (i = 0; i < bpfrm_pkg::NUM_BUFFERS; i++) begin
                free_q.push_back(bpfrm_pkg::IDX_W'(i));
                buf_status[i] = bpfrm_pkg::ST_FREE;
            end
            pending_results.delete();
        end else begin
            // results first: a result never belongs to a request taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                seen.granted_index = i_granted_index;
                seen.result_code   = i_result_code;
                seen.new_status    = i_new_status;
                seen.free_count    = i_free_count;
                seen.ready_count   = i_ready_count;
                if (pending_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t unexpected result", $realtime);
                        show_result("  actual  ", seen);
                    end
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (want !== seen) begin
                        if (mismatches < 10) begin
                            $display("%0t result mismatch", $realtime);
                            show_result("  expected", want);
                            show_result("  actual  ", seen);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(apply_pool_command(i_command, i_buffer_index));
        end
        o_pending_count <= pending_results.size();
    end

endmodule

// ===== tb/tb_buffer_pool_free_ready_manager_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_buffer_pool_free_ready_manager_top
// drives get, release and force-free requests into the buffer pool manager
// under several sender/receiver idling mixes; a side checker predicts and
// compares every result, this module only makes traffic and gives the verdict
// ============================================================================
module tb_buffer_pool_free_ready_manager_top;

    localparam int ITEMS_PER_PHASE  = 375;
    localparam int LONG_HOLD_CYCLES = 50;
    localparam int WATCHDOG_LIMIT   = 1000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        in_valid;
    logic [1:0]                  in_command;
    logic [bpfrm_pkg::IDX_W-1:0] in_index;
    logic                        out_stall;

    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [bpfrm_pkg::IDX_W-1:0] o_granted_index;
    logic [1:0]                  o_result_code;
    logic [1:0]                  o_new_status;
    logic [bpfrm_pkg::CNT_W-1:0] o_free_count;
    logic [bpfrm_pkg::CNT_W-1:0] o_ready_count;

    int fail_count;
    int pending_count;

    // traffic shaping knobs, owned by the main process
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requested = 0;

    // buffers we know are being written or read, good candidates to release
    logic [bpfrm_pkg::IDX_W-1:0] held_bufs[$];

    int quiet_cycles = 0;

    buffer_pool_free_ready_manager_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (in_command),
        .i_buffer_index  (in_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_granted_index (o_granted_index),
        .o_result_code   (o_result_code),
        .o_new_status    (o_new_status),
        .o_free_count    (o_free_count),
        .o_ready_count   (o_ready_count)
    );

    pool_result_checker u_pool_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (o_in_stall),
        .i_command       (in_command),
        .i_buffer_index  (in_index),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .i_granted_index (o_granted_index),
        .i_result_code   (o_result_code),
        .i_new_status    (o_new_status),
        .i_free_count    (o_free_count),
        .i_ready_count   (o_ready_count),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // receiver side: random stall, or a long counted hold-off when asked
    initial begin : rx_stall_gen
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        out_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requested) begin
                hold_served = hold_requested;
                hold_left   = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // learn which buffers were handed out, so releases mostly hit live buffers
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall &&
            o_result_code == bpfrm_pkg::RC_OK &&
            (o_new_status == bpfrm_pkg::ST_WRITE || o_new_status == bpfrm_pkg::ST_READ))
            held_bufs.push_back(o_granted_index);
    end

    // watchdog: too long without any handshake means the block hung
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("buffer_pool_free_ready_manager_top verification failed");
            $finish;
        end
    end

    // one request: optional random pick, sender gaps, then hold until taken
    task automatic issue_request(input bit pick, input logic [1:0] cmd,
                                 input logic [bpfrm_pkg::IDX_W-1:0] idx);
        int roll;
        int pos;
        @(negedge i_clk);
        if (pick) begin
            roll = $urandom_range(99);
            if (roll < 30)
                cmd = bpfrm_pkg::CMD_GET_WRITE;
            else if (roll < 60)
                cmd = bpfrm_pkg::CMD_GET_READ;
            else if (roll < 88)
                cmd = bpfrm_pkg::CMD_RELEASE;
            else
                cmd = bpfrm_pkg::CMD_FORCE;
            // get commands ignore the index, it still toggles the port
            idx = bpfrm_pkg::IDX_W'($urandom_range(bpfrm_pkg::NUM_BUFFERS - 1));
            if ((cmd == bpfrm_pkg::CMD_RELEASE || cmd == bpfrm_pkg::CMD_FORCE) &&
                held_bufs.size() > 0 && $urandom_range(99) < 75) begin
                pos = $urandom_range(held_bufs.size() - 1);
                idx = held_bufs[pos];
                held_bufs.delete(pos);
            end
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_index   <= idx;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // sender goes quiet until every outstanding result is back
    task automatic wait_for_drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    initial begin : stimulus
        int phase;
        int n;
        int tx_mix[4];
        int rx_mix[4];
        tx_mix = '{0, 45, 0, 29};
        rx_mix = '{0, 0, 45, 29};

        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_command = bpfrm_pkg::CMD_GET_WRITE;
        in_index   = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk from the reset pool
        issue_request(1'b0, bpfrm_pkg::CMD_GET_READ, 3'd0);   // ready queue empty
        issue_request(1'b0, bpfrm_pkg::CMD_RELEASE, 3'd7);    // release of a free buffer
        issue_request(1'b0, bpfrm_pkg::CMD_FORCE, 3'd0);      // force free of a free buffer
        for (n = 0; n < bpfrm_pkg::NUM_BUFFERS; n++)
            issue_request(1'b0, bpfrm_pkg::CMD_GET_WRITE,
                          bpfrm_pkg::IDX_W'(bpfrm_pkg::NUM_BUFFERS - 1 - n));
        issue_request(1'b0, bpfrm_pkg::CMD_GET_WRITE, 3'd7);  // free queue empty
        // written, no free buffer: back to free
        issue_request(1'b0, bpfrm_pkg::CMD_RELEASE, 3'd3);
        issue_request(1'b0, bpfrm_pkg::CMD_RELEASE, 3'd0);    // written: on to ready
        issue_request(1'b0, bpfrm_pkg::CMD_RELEASE, 3'd7);
        issue_request(1'b0, bpfrm_pkg::CMD_FORCE, 3'd3);      // force free of a free buffer
        issue_request(1'b0, bpfrm_pkg::CMD_FORCE, 3'd5);      // force free of a written buffer
        issue_request(1'b0, bpfrm_pkg::CMD_GET_READ, 3'd0);   // takes 0
        issue_request(1'b0, bpfrm_pkg::CMD_RELEASE, 3'd0);    // read, ready not empty: to free
        issue_request(1'b0, bpfrm_pkg::CMD_GET_READ, 3'd0);   // takes 7, ready now empty
        // read, no ready buffer: back to ready
        issue_request(1'b0, bpfrm_pkg::CMD_RELEASE, 3'd7);
        issue_request(1'b0, bpfrm_pkg::CMD_FORCE, 3'd7);      // force free of a ready buffer
        issue_request(1'b0, bpfrm_pkg::CMD_GET_READ, 3'd0);   // takes 7 again
        issue_request(1'b0, bpfrm_pkg::CMD_FORCE, 3'd7);      // force free of a read buffer
        issue_request(1'b0, bpfrm_pkg::CMD_RELEASE, 3'd2);
        wait_for_drain();

        // random traffic under each idling mix
        for (phase = 0; phase < 4; phase++) begin
            tx_idle_pct  = tx_mix[phase];
            rx_stall_pct = rx_mix[phase];
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off while the sender keeps pushing
                if (phase == 0 && n == 100)
                    hold_requested++;
                if (n == 200)
                    wait_for_drain();
                issue_request(1'b1, bpfrm_pkg::CMD_GET_WRITE, '0);
            end
            wait_for_drain();
        end

        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("buffer_pool_free_ready_manager_top verification clean");
        else
            $display("buffer_pool_free_ready_manager_top verification failed");
        $finish;
    end

endmodule
